### design/v2n_pkg.sv
package v2n_pkg;

  // Field widths of the stream items.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned LimW    = 31;
  localparam int unsigned UnitW   = 18;
  localparam int unsigned SqW     = 64;
  localparam int unsigned ProdW   = 63;

  // Pipeline depths of the shared root unit and of each lane divider.
  localparam int unsigned IsqStages = 32;
  localparam int unsigned DivQW     = 31;

  // What one lane hands on: the magnitude and its product with the limit.
  typedef struct packed {
    logic [CoordW-1:0] mag;
    logic [ProdW-1:0]  prod;
  } lane_t;

  // Raw item carried alongside the arithmetic.
  typedef struct packed {
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
    logic [LimW-1:0]   lim;
  } side_t;

endpackage

### design/v2n_lane.sv
module v2n_lane
  import v2n_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CoordW-1:0] raw_i,
  input  logic [LimW-1:0]   lim_i,
  output lane_t             lane_o,
  output logic [SqW-1:0]    sq_o
);

  logic [CoordW-1:0] mag_q;
  logic [LimW-1:0]   lim_q;
  logic [CoordW-1:0] mag2_q;
  logic [SqW-1:0]    sq_q;
  logic [ProdW-1:0]  prod_q;

  // First stage: magnitude of the two's complement component.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= raw_i[CoordW-1] ? (~raw_i + 32'd1) : raw_i;
      lim_q <= lim_i;
    end
  end

  // Second stage: square for the length and product for the clamp.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= SqW'(mag_q) * SqW'(mag_q);
      prod_q <= ProdW'(mag_q) * ProdW'(lim_q);
      mag2_q <= mag_q;
    end
  end

  assign lane_o.mag  = mag2_q;
  assign lane_o.prod = prod_q;
  assign sq_o        = sq_q;

endmodule

### design/v2n_isqrt.sv
module v2n_isqrt
  import v2n_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SqW-1:0]    rad_i,
  output logic [CoordW-1:0] root_o
);

  logic [32:0]       rem_q  [IsqStages];
  logic [CoordW-1:0] root_q [IsqStages];
  logic [SqW-1:0]    rad_q  [IsqStages];

  // One result bit per stage, two radicand bits brought down each time.
  for (genvar s = 0; s < IsqStages; s++) begin : g_stage
    logic [32:0]       rem_in;
    logic [CoordW-1:0] root_in;
    logic [SqW-1:0]    rad_in;
    logic [34:0]       trial;
    logic [34:0]       cand;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign trial = {rem_in, rad_in[SqW-1 -: 2]};
    assign cand  = {1'b0, root_in, 2'b01};
    assign ge    = (trial >= cand);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? 33'(trial - cand) : 33'(trial);
        root_q[s] <= {root_in[CoordW-2:0], ge};
        rad_q[s]  <= {rad_in[SqW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[IsqStages-1];

endmodule

### design/v2n_div.sv
module v2n_div
  import v2n_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ProdW-1:0]  num_i,
  input  logic [CoordW-1:0] den_i,
  output logic [DivQW-1:0]  quo_o,
  output logic [CoordW-1:0] den_o
);

  // The numerator is below den * 2^DivQW, so the upper part starts below den.
  logic [CoordW-1:0] rem_q [DivQW];
  logic [DivQW-1:0]  low_q [DivQW];
  logic [DivQW-1:0]  quo_q [DivQW];
  logic [CoordW-1:0] den_q [DivQW];

  // Restoring long division, one quotient bit per stage.
  for (genvar s = 0; s < DivQW; s++) begin : g_stage
    logic [CoordW-1:0] rem_in;
    logic [DivQW-1:0]  low_in;
    logic [DivQW-1:0]  quo_in;
    logic [CoordW-1:0] den_in;
    logic [CoordW:0]   trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i[ProdW-1:DivQW];
      assign low_in = num_i[DivQW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, low_in[DivQW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? CoordW'(trial - {1'b0, den_in}) : CoordW'(trial);
        low_q[s] <= {low_in[DivQW-2:0], 1'b0};
        quo_q[s] <= {quo_in[DivQW-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DivQW-1];
  assign den_o = den_q[DivQW-1];

endmodule

### design/vector2_length_normalize_clamp_top.sv
// Throughput: one vector per cycle while the output register is not held; a 32-stage
// root pipeline feeds four 31-stage dividers, two per component lane, all advancing
// together. The whole pipeline holds while the output register waits to be taken.
// Reset (rst_ni low, asynchronous) clears the valid bits; no data is cleared.
module vector2_length_normalize_clamp_top
  import v2n_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x [31:0], vec_y [63:32], limit_magnitude [94:64], zero [95]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vec_length [31:0], unit_x [49:32], unit_y [67:50], clamped_x [99:68],
  // clamped_y [131:100], zero [135:132]
  output logic [135:0] m_axis_tdata,
  // was_clamped [0], zero_length [1]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned Depth  = 2 + 1 + IsqStages + DivQW;
  localparam int unsigned MidLen = IsqStages + 1;

  logic        en;
  logic [Depth-1:0] vld_q;
  side_t       sd_q [Depth];
  lane_t       md_q [MidLen];
  lane_t       lane_x, lane_y;
  logic [SqW-1:0]    sq_x, sq_y, sum_q;
  logic [CoordW-1:0] root;
  side_t       in_side;

  logic [DivQW-1:0]  qux, quy, qcx, qcy;
  logic [CoordW-1:0] len, den_uy, den_cx, den_cy;

  logic              out_vld_q;
  logic [135:0]      out_data_q;
  logic [1:0]        out_user_q;

  // Global advance: the pipeline moves whenever the output can take a result.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign in_side.raw_x = s_axis_tdata[31:0];
  assign in_side.raw_y = s_axis_tdata[63:32];
  assign in_side.lim   = s_axis_tdata[94:64];

  // Valid bits follow the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // The raw item travels alongside for signs, limit and pass-through.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= in_side;
      for (int i = 1; i < Depth; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // Two component lanes: magnitude, square and limit product.
  v2n_lane u_lane_x (
    .clk_i (clk_i), .en_i (en), .raw_i (in_side.raw_x), .lim_i (in_side.lim),
    .lane_o (lane_x), .sq_o (sq_x)
  );
  v2n_lane u_lane_y (
    .clk_i (clk_i), .en_i (en), .raw_i (in_side.raw_y), .lim_i (in_side.lim),
    .lane_o (lane_y), .sq_o (sq_y)
  );

  // Sum of squares, then lane data delayed to meet the root.
  lane_t md_y_q [MidLen];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q     <= sq_x + sq_y;
      md_q[0]   <= lane_x;
      md_y_q[0] <= lane_y;
      for (int i = 1; i < MidLen; i++) begin
        md_q[i]   <= md_q[i-1];
        md_y_q[i] <= md_y_q[i-1];
      end
    end
  end

  v2n_isqrt u_isqrt (
    .clk_i (clk_i), .en_i (en), .rad_i (sum_q), .root_o (root)
  );

  // Per lane: one divider for the unit component, one for the clamp.
  logic [ProdW-1:0] num_ux, num_uy;
  assign num_ux = ProdW'(md_q[MidLen-1].mag) << FRAC_BITS;
  assign num_uy = ProdW'(md_y_q[MidLen-1].mag) << FRAC_BITS;

  v2n_div u_div_ux (
    .clk_i (clk_i), .en_i (en), .num_i (num_ux), .den_i (root),
    .quo_o (qux), .den_o (len)
  );
  v2n_div u_div_uy (
    .clk_i (clk_i), .en_i (en), .num_i (num_uy), .den_i (root),
    .quo_o (quy), .den_o (den_uy)
  );
  v2n_div u_div_cx (
    .clk_i (clk_i), .en_i (en), .num_i (md_q[MidLen-1].prod), .den_i (root),
    .quo_o (qcx), .den_o (den_cx)
  );
  v2n_div u_div_cy (
    .clk_i (clk_i), .en_i (en), .num_i (md_y_q[MidLen-1].prod), .den_i (root),
    .quo_o (qcy), .den_o (den_cy)
  );

  // Merge the lanes: flags, signs and the clamp selection.
  side_t             fin;
  logic              zero_len, clamp, nx, ny;
  logic [UnitW-1:0]  ux, uy;
  logic [CoordW-1:0] cx, cy;

  always_comb begin
    fin      = sd_q[Depth-1];
    nx       = fin.raw_x[CoordW-1];
    ny       = fin.raw_y[CoordW-1];
    zero_len = (len == '0);
    clamp    = !zero_len && (len > {1'b0, fin.lim});
    ux       = zero_len ? '0 : (nx ? (~UnitW'(qux) + 18'd1) : UnitW'(qux));
    uy       = zero_len ? '0 : (ny ? (~UnitW'(quy) + 18'd1) : UnitW'(quy));
    cx       = !clamp ? fin.raw_x
             : (nx ? (~{1'b0, qcx} + 32'd1) : {1'b0, qcx});
    cy       = !clamp ? fin.raw_y
             : (ny ? (~{1'b0, qcy} + 32'd1) : {1'b0, qcy});
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {4'b0, cy, cx, uy, ux, len};
      out_user_q <= {zero_len, clamp};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // A zero-length result has no direction, is never clamped and passes zeros.
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[67:32] == '0 && !m_axis_tuser[0] && m_axis_tdata[131:68] == '0)
    else $error("zero-length result carries a direction or clamp");

  // A clamped result always has a non-zero length.
  a_clamp_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] != '0)
    else $error("clamp flagged on a zero length");

  // An accepted item enters the first stage.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // A stalled pipeline keeps its final stage.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-1] && !en |=> vld_q[Depth-1])
    else $error("final stage dropped during a stall");

  // The lane dividers all see the same length.
  a_len_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-1] |-> len == den_uy && len == den_cx && len == den_cy)
    else $error("lane dividers disagree on the length");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import v2n_pkg::*;

  localparam int FracBits = 16;

  // One expected result of the block.
  typedef struct packed {
    logic [31:0] vec_length;
    logic [17:0] unit_x;
    logic [17:0] unit_y;
    logic [31:0] clamped_x;
    logic [31:0] clamped_y;
    logic        was_clamped;
    logic        zero_length;
  } vec_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  vec_result_t expected_q[$];
  int          fail_count;
  bit          sending_done;

  vector2_length_normalize_clamp_top #(.FRAC_BITS(FracBits)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Floor square root of a 64-bit sum, one result bit per step.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Works out length, unit vector and clamped vector for one item.
  function automatic vec_result_t predict_vector(input logic [31:0] x, input logic [31:0] y,
                                                 input logic [30:0] lim);
    vec_result_t r;
    logic [63:0] ax, ay, len, ux, uy, cx, cy;
    ax = x[31] ? {32'd0, -x} : {32'd0, x};
    ay = y[31] ? {32'd0, -y} : {32'd0, y};
    len = floor_sqrt(ax * ax + ay * ay);
    ux = '0;
    uy = '0;
    cx = {32'd0, x};
    cy = {32'd0, y};
    r.was_clamped = 1'b0;
    if (len != 0) begin
      ux = (ax << FracBits) / len;
      uy = (ay << FracBits) / len;
      if (x[31]) ux = -ux;
      if (y[31]) uy = -uy;
      if (len > {33'd0, lim}) begin
        r.was_clamped = 1'b1;
        cx = (ax * lim) / len;
        cy = (ay * lim) / len;
        if (x[31]) cx = -cx;
        if (y[31]) cy = -cy;
      end
    end
    r.vec_length  = len[31:0];
    r.unit_x      = ux[17:0];
    r.unit_y      = uy[17:0];
    r.clamped_x   = cx[31:0];
    r.clamped_y   = cy[31:0];
    r.zero_length = (len == 0);
    return r;
  endfunction

  // Sends one vector after a random gap and queues its expected result.
  // Entered at a falling edge; tvalid stays high on return for back-to-back transfers.
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [30:0] lim);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 5) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lim, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_vector(x, y, lim));
    @(negedge clk_i);
  endtask

  // Directed extremes: zero vector, axis and diagonal limits, limit edges.
  task automatic test_directed();
    send_vector(32'd0, 32'd0, 31'd0);
    send_vector(32'd0, 32'd0, 31'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h8000_0000, 31'd0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'd0, 31'h7FFF_FFFF);
    send_vector(32'd0, 32'h8000_0000, 31'd65536);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
    send_vector(32'd1, 32'd0, 31'd0);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0);
    send_vector(32'd1, 32'd1, 31'd1);
    send_vector(32'd3 << 16, 32'd4 << 16, 31'd5 << 16);
    send_vector(32'd3 << 16, 32'd4 << 16, (31'd5 << 16) - 31'd1);
    send_vector(-(32'd3 << 16), 32'd4 << 16, 31'd2 << 16);
    send_vector(32'd65536, 32'd0, 31'd65536);
    send_vector(32'h0001_0000, 32'hFFFF_0000, 31'd0);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
  endtask

  // Random vectors with mixed magnitudes and limits near the length.
  task automatic test_random(input int count);
    logic [31:0] x, y;
    logic [30:0] lim;
    logic [63:0] ax, ay, len;
    for (int i = 0; i < count; i++) begin
      x = $urandom;
      y = $urandom;
      case ($urandom_range(0, 3))
        0: begin
          x = $signed(x) >>> $urandom_range(0, 31);
          y = $signed(y) >>> $urandom_range(0, 31);
        end
        1: y = $signed(y) >>> $urandom_range(8, 31);
        default: ;
      endcase
      ax = x[31] ? {32'd0, -x} : {32'd0, x};
      ay = y[31] ? {32'd0, -y} : {32'd0, y};
      len = floor_sqrt(ax * ax + ay * ay);
      case ($urandom_range(0, 4))
        0: lim = 31'($urandom);
        1: lim = 31'($urandom >> $urandom_range(0, 30));
        2: lim = (len > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : len[30:0];
        3: lim = (len == 0 || len > 64'h8000_0000) ? 31'd0 : len[30:0] - 31'd1;
        default: lim = len[30:0] >> 1;
      endcase
      send_vector(x, y, lim);
    end
  endtask

  // Output side: random stalls, checks each transfer against the oldest expectation.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int stall;
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 7) == 0) stall = 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      begin
        vec_result_t got, exp_r;
        got.vec_length  = m_axis_tdata[31:0];
        got.unit_x      = m_axis_tdata[49:32];
        got.unit_y      = m_axis_tdata[67:50];
        got.clamped_x   = m_axis_tdata[99:68];
        got.clamped_y   = m_axis_tdata[131:100];
        got.was_clamped = m_axis_tuser[0];
        got.zero_length = m_axis_tuser[1];
        if (expected_q.size() == 0) begin
          $error("unexpected transfer: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.vec_length !== exp_r.vec_length) begin
            $error("vec_length: expected %h, got %h", exp_r.vec_length, got.vec_length);
            fail_count++;
          end
          if (got.unit_x !== exp_r.unit_x) begin
            $error("unit_x: expected %h, got %h", exp_r.unit_x, got.unit_x);
            fail_count++;
          end
          if (got.unit_y !== exp_r.unit_y) begin
            $error("unit_y: expected %h, got %h", exp_r.unit_y, got.unit_y);
            fail_count++;
          end
          if (got.clamped_x !== exp_r.clamped_x) begin
            $error("clamped_x: expected %h, got %h", exp_r.clamped_x, got.clamped_x);
            fail_count++;
          end
          if (got.clamped_y !== exp_r.clamped_y) begin
            $error("clamped_y: expected %h, got %h", exp_r.clamped_y, got.clamped_y);
            fail_count++;
          end
          if (got.was_clamped !== exp_r.was_clamped) begin
            $error("was_clamped: expected %b, got %b", exp_r.was_clamped, got.was_clamped);
            fail_count++;
          end
          if (got.zero_length !== exp_r.zero_length) begin
            $error("zero_length: expected %b, got %b", exp_r.zero_length, got.zero_length);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1134);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
design/v2n_pkg.sv
design/v2n_lane.sv
design/v2n_isqrt.sv
design/v2n_div.sv
design/vector2_length_normalize_clamp_top.sv
verif/tb_top.sv
